[sv/tcfod_pkg.sv]
// Shared types, codes and defaults for the two-class oldest-first queue block.
`default_nettype none

package tcfod_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF    = 16;
    localparam int FIELD_ID_W      = 16;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;
    typedef logic [2:0] t_op;

    localparam t_req REQ_ENQ     = 2'd0;
    localparam t_req REQ_DEQ_ANY = 2'd1;
    localparam t_req REQ_DEQ1    = 2'd2;
    localparam t_req REQ_DEQ0    = 2'd3;

    localparam t_kind KIND_C0 = 2'd0;
    localparam t_kind KIND_C1 = 2'd1;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_EMPTY   = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_UNKNOWN = 2'd3;

    localparam t_op OP_PUSH0   = 3'd0;
    localparam t_op OP_PUSH1   = 3'd1;
    localparam t_op OP_IGNORE  = 3'd2;
    localparam t_op OP_DEQ_ANY = 3'd3;
    localparam t_op OP_DEQ1    = 3'd4;
    localparam t_op OP_DEQ0    = 3'd5;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_cmd_ctl;

endpackage

`default_nettype wire

[sv/tcfod_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcfod_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/tcfod_front.sv]
// Front end: accepts requests, classifies them and holds them in a two-entry command queue.
`default_nettype none

module tcfod_front import tcfod_pkg::*; #(
    parameter int ID_WIDTH = ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_req                  i_req_type,
    input  logic [FIELD_ID_W-1:0] i_item_id,
    input  t_kind                 i_item_kind,
    output logic                  o_busy,
    output t_cmd_ctl              o_cmd,
    output logic [ID_WIDTH-1:0]   o_cmd_id,
    input  logic                  i_cmd_take
);

    t_op               r_op [2];
    logic [ID_WIDTH-1:0] r_id [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              w_accept;
    t_op               w_op;

    assign o_busy   = (r_cnt == 2'd2);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        case (i_req_type)
            REQ_ENQ: begin
                if (i_item_kind == KIND_C0) begin
                    w_op = OP_PUSH0;
                end else if (i_item_kind == KIND_C1) begin
                    w_op = OP_PUSH1;
                end else begin
                    w_op = OP_IGNORE;
                end
            end
            REQ_DEQ_ANY: begin
                w_op = OP_DEQ_ANY;
            end
            REQ_DEQ1: begin
                w_op = OP_DEQ1;
            end
            REQ_DEQ0: begin
                w_op = OP_DEQ0;
            end
            default: begin
                w_op = OP_IGNORE;
            end
        endcase
    end

    assign n_cnt = r_cnt + {1'b0, w_accept} - {1'b0, i_cmd_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_accept) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_take) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op[r_wr_ptr] <= w_op;
            r_id[r_wr_ptr] <= ID_WIDTH'(i_item_id);
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.op    = r_op[r_rd_ptr];
    assign o_cmd_id    = r_id[r_rd_ptr];

endmodule

`default_nettype wire

[sv/tcfod_back.sv]
// Back end: runs each queued command against the two class queues and drives the result.
`default_nettype none

module tcfod_back import tcfod_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd_ctl              i_cmd,
    input  logic [ID_WIDTH-1:0]   i_cmd_id,
    output logic                  o_cmd_take,
    output logic                  o_strobe,
    output t_status               o_status,
    output logic [FIELD_ID_W-1:0] o_out_id,
    output logic                  o_out_kind
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [ADDR_W:0]   DEPTH_S = (ADDR_W + 1)'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST    = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_C  = CNT_W'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    t_op                 r_op;
    logic [ID_WIDTH-1:0] r_id;
    logic [ADDR_W-1:0]   r_head0;
    logic [ADDR_W-1:0]   r_head1;
    logic [CNT_W-1:0]    r_cnt0;
    logic [CNT_W-1:0]    r_cnt1;
    logic                r_strobe;
    t_status             r_status;
    logic [FIELD_ID_W-1:0] r_out_id;
    logic                r_out_kind;

    logic [ADDR_W:0]     w_sum0;
    logic [ADDR_W:0]     w_sum1;
    logic [ADDR_W-1:0]   w_waddr0;
    logic [ADDR_W-1:0]   w_waddr1;
    logic [ID_WIDTH-1:0] w_rd0;
    logic [ID_WIDTH-1:0] w_rd1;
    logic                w_e0;
    logic                w_e1;
    logic                w_f0;
    logic                w_f1;
    logic                w_exec;
    logic                w_we0;
    logic                w_we1;
    logic                w_take0;
    logic                w_take1;
    t_status             w_status;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd.valid;
    assign w_exec     = (r_state == S_EXEC);

    assign w_sum0   = {1'b0, r_head0} + (ADDR_W + 1)'(r_cnt0);
    assign w_sum1   = {1'b0, r_head1} + (ADDR_W + 1)'(r_cnt1);
    assign w_waddr0 = ADDR_W'((w_sum0 >= DEPTH_S) ? (w_sum0 - DEPTH_S) : w_sum0);
    assign w_waddr1 = ADDR_W'((w_sum1 >= DEPTH_S) ? (w_sum1 - DEPTH_S) : w_sum1);

    assign w_e0 = (r_cnt0 == '0);
    assign w_e1 = (r_cnt1 == '0);
    assign w_f0 = (r_cnt0 == FULL_C);
    assign w_f1 = (r_cnt1 == FULL_C);

    tcfod_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr0),
        .i_wdata (r_id),
        .i_raddr (r_head0),
        .o_rdata (w_rd0)
    );

    tcfod_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr1),
        .i_wdata (r_id),
        .i_raddr (r_head1),
        .o_rdata (w_rd1)
    );

    always_comb begin
        w_we0    = 1'b0;
        w_we1    = 1'b0;
        w_take0  = 1'b0;
        w_take1  = 1'b0;
        w_status = ST_OK;
        case (r_op)
            OP_PUSH0: begin
                if (w_f0) begin
                    w_status = ST_FULL;
                end else begin
                    w_we0 = w_exec;
                end
            end
            OP_PUSH1: begin
                if (w_f1) begin
                    w_status = ST_FULL;
                end else begin
                    w_we1 = w_exec;
                end
            end
            OP_IGNORE: begin
                w_status = ST_UNKNOWN;
            end
            OP_DEQ_ANY: begin
                if (w_e0 && w_e1) begin
                    w_status = ST_EMPTY;
                end else if (w_e0) begin
                    w_take1 = w_exec;
                end else if (w_e1) begin
                    w_take0 = w_exec;
                end else if (w_rd0 < w_rd1) begin
                    w_take0 = w_exec;
                end else begin
                    w_take1 = w_exec;
                end
            end
            OP_DEQ1: begin
                if (w_e1) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_take1 = w_exec;
                end
            end
            OP_DEQ0: begin
                if (w_e0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_take0 = w_exec;
                end
            end
            default: begin
                w_status = ST_UNKNOWN;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE: begin
                n_state = i_cmd.valid ? S_READ : S_IDLE;
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head0  <= '0;
            r_head1  <= '0;
            r_cnt0   <= '0;
            r_cnt1   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_exec;
            if (w_take0) begin
                r_head0 <= (r_head0 == LAST) ? '0 : r_head0 + 1'b1;
            end
            if (w_take1) begin
                r_head1 <= (r_head1 == LAST) ? '0 : r_head1 + 1'b1;
            end
            r_cnt0 <= r_cnt0 + CNT_W'(w_we0) - CNT_W'(w_take0);
            r_cnt1 <= r_cnt1 + CNT_W'(w_we1) - CNT_W'(w_take1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_op <= i_cmd.op;
            r_id <= i_cmd_id;
        end
        if (w_exec) begin
            r_status   <= w_status;
            r_out_kind <= w_take1;
            if (w_take0) begin
                r_out_id <= FIELD_ID_W'(w_rd0);
            end else if (w_take1) begin
                r_out_id <= FIELD_ID_W'(w_rd1);
            end else begin
                r_out_id <= '0;
            end
        end
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_out_id   = r_out_id;
    assign o_out_kind = r_out_kind;

endmodule

`default_nettype wire

[sv/two_class_fifo_oldest_dequeue.sv]
// Top level of the two-class queue block with oldest-first dequeue.
// A request is taken at a clock edge with start high and busy low and lands in a
// two-entry command queue, so busy rises only when two requests are waiting. The
// execution side handles each request in three steps: taking it from the command
// queue, the registered read of both queue heads, and comparing the fronts, updating
// the queue and registering the result. It takes no new request from the command
// queue until the last one has finished all three steps. Each result is shown for one
// cycle with o_strobe high and cannot be held off by the receiver. The queue stores
// need no clearing after reset.
`default_nettype none

module two_class_fifo_oldest_dequeue import tcfod_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [FIELD_ID_W-1:0] i_item_id,
    input  logic [1:0]            i_item_kind,
    output logic                  o_strobe,
    output logic [1:0]            o_status,
    output logic [FIELD_ID_W-1:0] o_out_id,
    output logic                  o_out_kind
);

    t_cmd_ctl            w_cmd;
    logic [ID_WIDTH-1:0] w_cmd_id;
    logic                w_cmd_take;

    tcfod_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req_type),
        .i_item_id   (i_item_id),
        .i_item_kind (i_item_kind),
        .o_busy      (busy),
        .o_cmd       (w_cmd),
        .o_cmd_id    (w_cmd_id),
        .i_cmd_take  (w_cmd_take)
    );

    tcfod_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cmd_id   (w_cmd_id),
        .o_cmd_take (w_cmd_take),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_out_id   (o_out_id),
        .o_out_kind (o_out_kind)
    );

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("Two result strobes in consecutive cycles.");

    a_no_pop_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_out_id == '0 && !o_out_kind))
        else $error("Failed transaction carries a dequeued item.");

    a_take_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take |-> w_cmd.valid)
        else $error("Command taken from an empty command queue.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("Strobe or busy active right after reset.");

endmodule

`default_nettype wire
